// ===== sv/psf_pkg.sv =====
// Shared types and constants for the pencil sketch pixel filter.
// Depends on nothing; the top level and psf_row_cell import it, as does the bench.
package psf_pkg;

  // Defaults for the top level parameters.
  localparam int unsigned MaxWidthDef     = 2048;
  localparam int unsigned WindowRadiusDef = 7;

  // Fixed frame limits and field widths.
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned RowW      = 12;  // row counters, 0 .. MaxHeight-1
  localparam int unsigned ColAddrW  = 12;  // column address on the chain, MaxWidth up to 4096
  localparam int unsigned ColSumW   = 13;  // one column of inverted gray, radius up to 15
  localparam int unsigned FwW       = 12;
  localparam int unsigned FhW       = 13;
  localparam int unsigned CfgIdxW   = 4;
  localparam int unsigned CfgDataW  = 13;

  // Luminance weights in Q16.
  localparam logic [15:0] GrayWtRed   = 16'd13933;
  localparam logic [15:0] GrayWtGreen = 16'd46871;
  localparam logic [15:0] GrayWtBlue  = 16'd4732;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 4'd0,
    CFG_FRAME_HEIGHT = 4'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       flush;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] sketch_value;
    logic       frame_end;
  } pix_out_t;

  // Token that walks down the chain of row cells, one column of the window.
  typedef struct packed {
    logic                valid;
    logic                last;
    logic                center;
    logic [ColAddrW-1:0] addr;
    logic [ColSumW-1:0]  psum;
    logic [7:0]          gray;
  } col_tok_t;

  // Write into one row bank.
  typedef struct packed {
    logic                en;
    logic [ColAddrW-1:0] addr;
    logic [7:0]          data;
  } row_wr_t;

endpackage

// ===== sv/pencil_sketch_pixel_filter.sv =====
// Pencil sketch filter: gray, blurred inverted gray over a box, color dodge.
// Uses psf_pkg, psf_row_cell (with psf_ram) and psf_divider.
//
// Usage
//   in channel : RGB pixels in raster order, one beat per pixel. A beat with
//                flush set carries no pixel and drains one pending result.
//   out channel: one sketch value per pixel, same raster order; frame_end
//                marks the last pixel of the frame.
//   cfg channel: frame_width (index 0) and frame_height (index 1). A write
//                restarts the frame; write only while the block is idle.
// Latency: the result of pixel (r,c) leaves with the beat that brings the
//   pixel WindowRadius rows and WindowRadius columns later; after the last
//   pixel the remaining results come out one per flush beat.
// Processing: a pixel that gives no result is only written to the line store. One
//   that gives a result also sums its window: the window columns are fed one
//   per cycle down a chain of 2R+2 row cells, then the blur scale and the
//   divider finish the dodge. No new beat is taken until the block is idle.
// Reset: counters clear, size registers go to 640 x 480. The line store is
//   not cleared; it is always written before it is read.
// Stall: a finished result waits in the output register while the next beat
//   is taken; processing holds only if another result is ready before then.
module pencil_sketch_pixel_filter
  import psf_pkg::*;
#(
  parameter int unsigned MaxWidth     = MaxWidthDef,
  parameter int unsigned WindowRadius = WindowRadiusDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pix_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pix_out_t            out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned KeptRows = 2 * WindowRadius + 2;
  localparam int unsigned SlotW    = $clog2(KeptRows);
  localparam int unsigned BoxArea  = (2 * WindowRadius + 1) * (2 * WindowRadius + 1);
  localparam int unsigned SumW     = $clog2(255 * BoxArea + 1);
  localparam int unsigned RecipK   = SumW;
  localparam int unsigned RecipM   = (2 ** RecipK) / BoxArea;
  localparam int unsigned RecipW   = $clog2(RecipM + 1);
  localparam int unsigned ProdW    = SumW + RecipW;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned WidthW   = $clog2(MaxWidth + 1);
  localparam int unsigned LagW     = $clog2(WindowRadius * MaxWidth + WindowRadius + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_WRITE, ST_SWEEP, ST_DRAIN, ST_BLUR_MUL, ST_BLUR_CHK, ST_BLUR_FIX,
    ST_DIVIDE, ST_RESULT
  } state_e;

  state_e                state_q;
  logic [FwW-1:0]        fw_q;
  logic [FhW-1:0]        fh_q;
  logic [ColW-1:0]       in_col_q, out_col_q;
  logic [RowW-1:0]       in_row_q, out_row_q;
  logic [SlotW-1:0]      in_slot_q, out_slot_q;
  logic                  in_done_q;
  logic [LagW-1:0]       fill_q;
  logic [7:0]            red_q, green_q, blue_q;
  logic [ColW-1:0]       inj_col_q, last_col_q;
  logic [KeptRows-1:0]   mask_q, cen_q;
  logic [SumW-1:0]       acc_q;
  logic [7:0]            gray_q;
  logic [ProdW-1:0]      prod_q;
  logic [7:0]            qest_q;
  logic [SumW-1:0]       chk_q;
  logic [7:0]            res_q;
  pix_out_t              out_q;
  logic                  out_valid_q;

  logic [WidthW-1:0]     frame_w;
  logic [FhW-1:0]        frame_h;
  logic [ColW-1:0]       w_last;
  logic [RowW-1:0]       h_last;
  logic [LagW-1:0]       lag;
  logic [23:0]           gray_sum;
  logic [7:0]            gray_val;
  logic [ColW-1:0]       col_lo, col_hi;
  logic [ColW:0]         col_hi_w;
  logic [KeptRows-1:0]   win_inc, win_cen;
  logic [SumW-1:0]       rem_b;
  logic [7:0]            blur, den;
  logic                  frame_last;
  logic                  in_fire, cfg_hit, restart, start_emit;
  logic                  div_start, div_done;
  logic [7:0]            div_quo;
  col_tok_t              chain_tok [KeptRows+1];
  row_wr_t               row_wr [KeptRows];
  col_tok_t              tok_end;

  // Clamp the size registers to what the store can hold.
  assign frame_w = (fw_q == '0) ? WidthW'(1) :
                   ((32'(fw_q) > MaxWidth) ? WidthW'(MaxWidth) : WidthW'(fw_q));
  assign frame_h = (fh_q == '0) ? FhW'(1) :
                   ((32'(fh_q) > MaxHeight) ? FhW'(MaxHeight) : fh_q);
  assign w_last  = ColW'(frame_w - WidthW'(1));
  assign h_last  = RowW'(frame_h - FhW'(1));
  assign lag     = LagW'(32'(frame_w) * WindowRadius + WindowRadius);

  // Q16 luminance, truncated.
  assign gray_sum = 24'(red_q) * 24'(GrayWtRed) + 24'(green_q) * 24'(GrayWtGreen) +
                    24'(blue_q) * 24'(GrayWtBlue);
  assign gray_val = gray_sum[23:16];

  // Horizontal extent of the window, cut at the frame edges.
  assign col_lo   = (32'(out_col_q) >= WindowRadius) ? out_col_q - ColW'(WindowRadius) : '0;
  assign col_hi_w = {1'b0, out_col_q} + (ColW+1)'(WindowRadius);
  assign col_hi   = (col_hi_w >= {1'b0, w_last}) ? w_last : col_hi_w[ColW-1:0];

  assign in_fire    = in_valid_i && in_ready_o;
  assign cfg_hit    = cfg_valid_i && ((cfg_index_i == CFG_FRAME_WIDTH) ||
                                      (cfg_index_i == CFG_FRAME_HEIGHT));
  assign frame_last = (out_col_q == w_last) && (out_row_q == h_last);
  assign restart    = cfg_hit || ((state_q == ST_RESULT) && !out_valid_q && frame_last);
  assign start_emit = ((state_q == ST_IDLE) && in_fire && in_done_q) ||
                      ((state_q == ST_WRITE) && (fill_q == lag));

  // Blur correction: the reciprocal estimate is at most one low.
  assign rem_b     = acc_q - chk_q;
  assign blur      = qest_q + 8'(rem_b >= SumW'(BoxArea));
  assign den       = 8'd255 - blur;
  assign div_start = (state_q == ST_BLUR_FIX) && (den != 8'd0);

  // Feed one window column per cycle into the head of the chain.
  always_comb begin
    chain_tok[0]        = '0;
    chain_tok[0].valid  = (state_q == ST_SWEEP);
    chain_tok[0].last   = (inj_col_q == last_col_q);
    chain_tok[0].center = (inj_col_q == out_col_q);
    chain_tok[0].addr   = ColAddrW'(inj_col_q);
  end

  assign tok_end = chain_tok[KeptRows];

  // Row cells: one kept row each. A cell counts in the sum when its row
  // lies inside the frame part of the vertical window.
  for (genvar gi = 0; gi < KeptRows; gi++) begin : g_row
    logic [SlotW:0]   row_gap_w;
    logic [SlotW-1:0] row_gap;

    assign row_gap_w = (SlotW'(gi) >= out_slot_q) ?
                       ((SlotW+1)'(gi) - {1'b0, out_slot_q}) :
                       ((SlotW+1)'(gi + KeptRows) - {1'b0, out_slot_q});
    assign row_gap   = row_gap_w[SlotW-1:0];

    assign win_inc[gi] = (32'(row_gap) <= WindowRadius) ?
                         (({1'b0, out_row_q} + (RowW+1)'(row_gap)) <= {1'b0, h_last}) :
                         ((32'(row_gap) == WindowRadius + 1) ? 1'b0 :
                          (out_row_q >= RowW'(KeptRows - 32'(row_gap))));
    assign win_cen[gi] = (out_slot_q == SlotW'(gi));

    assign row_wr[gi].en   = (state_q == ST_WRITE) && (in_slot_q == SlotW'(gi));
    assign row_wr[gi].addr = ColAddrW'(in_col_q);
    assign row_wr[gi].data = gray_val;

    psf_row_cell #(
      .MaxWidth(MaxWidth)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .wr_i    (row_wr[gi]),
      .en_i    (mask_q[gi]),
      .center_i(cen_q[gi]),
      .tok_i   (chain_tok[gi]),
      .tok_o   (chain_tok[gi+1])
    );
  end

  psf_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  ({gray_q, 8'h00}),
    .den_i  (den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fw_q        <= FwW'(640);
      fh_q        <= FhW'(480);
      in_col_q    <= '0;
      in_row_q    <= '0;
      in_slot_q   <= '0;
      in_done_q   <= 1'b0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      out_slot_q  <= '0;
      fill_q      <= '0;
      red_q       <= '0;
      green_q     <= '0;
      blue_q      <= '0;
      inj_col_q   <= '0;
      last_col_q  <= '0;
      mask_q      <= '0;
      cen_q       <= '0;
      acc_q       <= '0;
      gray_q      <= '0;
      prod_q      <= '0;
      qest_q      <= '0;
      chk_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      // Sum column totals as they drop off the end of the chain.
      if (tok_end.valid) begin
        acc_q <= acc_q + SumW'(tok_end.psum);
        if (tok_end.center) begin
          gray_q <= tok_end.gray;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire && !in_data_i.flush && !in_done_q) begin
            red_q   <= in_data_i.red;
            green_q <= in_data_i.green;
            blue_q  <= in_data_i.blue;
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (in_col_q == w_last) begin
            in_col_q <= '0;
            if (in_row_q == h_last) begin
              in_done_q <= 1'b1;
            end else begin
              in_row_q  <= in_row_q + RowW'(1);
              in_slot_q <= (in_slot_q == SlotW'(KeptRows - 1)) ? '0 : in_slot_q + SlotW'(1);
            end
          end else begin
            in_col_q <= in_col_q + ColW'(1);
          end
          if (fill_q != lag) begin
            fill_q  <= fill_q + LagW'(1);
            state_q <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          inj_col_q <= inj_col_q + ColW'(1);
          if (inj_col_q == last_col_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (tok_end.valid && tok_end.last) begin
            state_q <= ST_BLUR_MUL;
          end
        end
        ST_BLUR_MUL: begin
          prod_q  <= ProdW'(acc_q) * ProdW'(RecipM);
          state_q <= ST_BLUR_CHK;
        end
        ST_BLUR_CHK: begin
          qest_q  <= prod_q[RecipK +: 8];
          chk_q   <= SumW'(32'(prod_q[RecipK +: 8]) * BoxArea);
          state_q <= ST_BLUR_FIX;
        end
        ST_BLUR_FIX: begin
          if (den == 8'd0) begin
            res_q   <= 8'd0;
            state_q <= ST_RESULT;
          end else begin
            state_q <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            res_q   <= div_quo;
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          // Hold until the previous result has left the output register.
          if (!out_valid_q) begin
            out_q.sketch_value <= res_q;
            out_q.frame_end    <= frame_last;
            out_valid_q        <= 1'b1;
            state_q            <= ST_IDLE;
            // The last pixel of the frame leaves the positions to the restart.
            if (!frame_last) begin
              if (out_col_q == w_last) begin
                out_col_q  <= '0;
                out_row_q  <= out_row_q + RowW'(1);
                out_slot_q <= (out_slot_q == SlotW'(KeptRows - 1)) ?
                              '0 : out_slot_q + SlotW'(1);
              end else begin
                out_col_q <= out_col_q + ColW'(1);
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      // Open the window for the next result.
      if (start_emit) begin
        inj_col_q  <= col_lo;
        last_col_q <= col_hi;
        mask_q     <= win_inc;
        cen_q      <= win_cen;
        acc_q      <= '0;
        state_q    <= ST_SWEEP;
      end

      if (cfg_valid_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_FRAME_WIDTH:  fw_q <= cfg_data_i[FwW-1:0];
          CFG_FRAME_HEIGHT: fh_q <= cfg_data_i[FhW-1:0];
          default: ;
        endcase
      end

      // Drop all positions: end of frame or new frame size.
      if (restart) begin
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_slot_q  <= '0;
        in_done_q  <= 1'b0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_slot_q <= '0;
        fill_q     <= '0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Column tokens only travel while a window is being summed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_end.valid |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
    else $error("column token left the chain outside a window pass");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIVIDE))
    else $error("divider finished while no division was pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= lag)
    else $error("pipeline fill count passed the window lag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && out_q.frame_end) |->
      (out_col_q == '0 && out_row_q == '0 && !in_done_q && fill_q == '0))
    else $error("frame end result did not restart the frame");

endmodule

// ===== sv/psf_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// Depends on nothing.
module psf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_o <= mem_q[rd_addr_i];
  end

endmodule

// ===== sv/psf_row_cell.sv =====
// One cell of the row chain: owns one kept row of gray values in a RAM bank
// and adds its inverted gray to the column token. Uses psf_pkg and psf_ram.
module psf_row_cell
  import psf_pkg::*;
#(
  parameter int unsigned MaxWidth = MaxWidthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  row_wr_t  wr_i,
  input  logic     en_i,
  input  logic     center_i,
  input  col_tok_t tok_i,
  output col_tok_t tok_o
);

  localparam int unsigned AddrW = $clog2(MaxWidth);

  col_tok_t   tok_q;
  logic [7:0] rd_data;
  logic [7:0] inv_gray;

  psf_ram #(
    .Width(8),
    .Depth(MaxWidth)
  ) u_ram (
    .clk_i    (clk_i),
    .wr_en_i  (wr_i.en),
    .wr_addr_i(wr_i.addr[AddrW-1:0]),
    .wr_data_i(wr_i.data),
    .rd_addr_i(tok_i.addr[AddrW-1:0]),
    .rd_data_o(rd_data)
  );

  // Read data lines up with the token registered on the same edge.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_i;
    end
  end

  assign inv_gray = ~rd_data;

  always_comb begin
    tok_o = tok_q;
    if (en_i) begin
      tok_o.psum = tok_q.psum + ColSumW'(inv_gray);
    end
    if (center_i && tok_q.center) begin
      tok_o.gray = rd_data;
    end
  end

endmodule

// ===== sv/psf_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle, with
// round-half-even and saturation to 8 bits. Depends on nothing.
module psf_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] num_i,
  input  logic [7:0]  den_i,
  output logic        done_o,
  output logic [7:0]  quo_o
);

  localparam logic [3:0] LastStep = 4'd15;

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_ROUND} dv_state_e;

  dv_state_e   state_q;
  logic [3:0]  cnt_q;
  logic [15:0] num_q;
  logic [7:0]  den_q;
  logic [7:0]  rem_q;
  logic [7:0]  quo_q;
  logic        done_q;

  logic [8:0]  part;
  logic [8:0]  part_sub;
  logic        take;
  logic [8:0]  twice_rem;
  logic        round_up;
  logic [16:0] q_rnd;
  logic [7:0]  q_sat;

  assign part      = {rem_q, num_q[15]};
  assign take      = part >= {1'b0, den_q};
  assign part_sub  = part - {1'b0, den_q};
  assign twice_rem = {rem_q, 1'b0};
  assign round_up  = (twice_rem > {1'b0, den_q}) ||
                     ((twice_rem == {1'b0, den_q}) && num_q[0]);
  assign q_rnd     = {1'b0, num_q} + 17'(round_up);
  assign q_sat     = (q_rnd > 17'd255) ? 8'd255 : q_rnd[7:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DV_IDLE;
      cnt_q   <= '0;
      num_q   <= '0;
      den_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == DV_ROUND);
      case (state_q)
        DV_IDLE: begin
          if (start_i) begin
            num_q   <= num_i;
            den_q   <= den_i;
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= DV_RUN;
          end
        end
        DV_RUN: begin
          num_q <= {num_q[14:0], take};
          rem_q <= take ? part_sub[7:0] : part[7:0];
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == LastStep) begin
            state_q <= DV_ROUND;
          end
        end
        DV_ROUND: begin
          quo_q   <= q_sat;
          state_q <= DV_IDLE;
        end
        default: state_q <= DV_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for pencil_sketch_pixel_filter: gray, box blur and color dodge.
// Depends on psf_pkg and the block RTL; it has its own sketch predictor and drives random traffic.
`timescale 1ns / 100ps

module testbench;
  import psf_pkg::*;

  localparam int unsigned Radius    = 7;
  localparam int unsigned KeptRows  = 2 * Radius + 2;
  localparam int unsigned StoreCols = 2048;
  localparam int unsigned BoxArea   = (2 * Radius + 1) * (2 * Radius + 1);
  localparam int unsigned HoldOff   = 80;    // wait after the last expected result is out
  localparam int unsigned StallLimit = 3000;  // cycles with no beat on any channel
  localparam int unsigned RandomItems = 1150;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 4'd9;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  pix_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  pix_out_t            out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  pencil_sketch_pixel_filter u_top (.*);

  // Sketch predictor state, a private copy of the block's frame position and line store.
  int unsigned width_reg, height_reg;
  int unsigned in_col, in_row, out_col, out_row;
  bit          frame_taken;
  logic [7:0]  gray_rows [KeptRows * StoreCols];

  pix_out_t sketch_q[$];
  int       mismatches;
  int       random_items;
  bit       steady_in, steady_out;   // suppress idling on the in or out side
  int       quiet_cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg & 12'hFFF;
    if (w < 1) w = 1;
    if (w > StoreCols) w = StoreCols;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg & 13'h1FFF;
    if (h < 1) h = 1;
    if (h > 4096) h = 4096;
    return h;
  endfunction

  function automatic int unsigned slot(int unsigned row, int unsigned col);
    return (row % KeptRows) * StoreCols + (col % StoreCols);
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    frame_taken = 1'b0;
  endfunction

  // Dodge the pixel at the output position, push the value, advance.
  function automatic void emit_sketch();
    int unsigned w, h, r0, c0, r1, c1, sum, blur, gray, den, num, q, rem;
    pix_out_t res;
    w = eff_width();
    h = eff_height();
    r0 = (out_row >= Radius) ? out_row - Radius : 0;
    c0 = (out_col >= Radius) ? out_col - Radius : 0;
    r1 = out_row + Radius + 1;
    c1 = out_col + Radius + 1;
    if (r1 > h) r1 = h;
    if (c1 > w) c1 = w;
    sum = 0;
    for (int unsigned i = r0; i < r1; i++)
      for (int unsigned j = c0; j < c1; j++)
        sum += 255 - gray_rows[slot(i, j)];
    blur = sum / BoxArea;
    gray = gray_rows[slot(out_row, out_col)];
    den = 255 - blur;
    if (den == 0) begin
      q = 0;
    end else begin
      num = gray * 256;
      q = num / den;
      rem = num % den;
      // round half to even
      if (2 * rem > den || (2 * rem == den && q[0])) q++;
      if (q > 255) q = 255;
    end
    res.sketch_value = q[7:0];
    res.frame_end = 1'b0;
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= h) begin
      res.frame_end = 1'b1;
      restart_frame();
    end
    sketch_q.push_back(res);
  endfunction

  // Update the predictor for one accepted input beat.
  function automatic void take_pixel(pix_in_t px);
    int unsigned w, h, lag, lin;
    w = eff_width();
    h = eff_height();
    lag = Radius * w + Radius;
    // A pixel during draining is dropped and acts as a flush.
    if (px.flush || frame_taken) begin
      if (frame_taken) emit_sketch();
      return;
    end
    gray_rows[slot(in_row, in_col)] =
      8'((32'd13933 * px.red + 32'd46871 * px.green + 32'd4732 * px.blue) >> 16);
    lin = in_row * w + in_col;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (in_row >= h) frame_taken = 1'b1;
    if (lin >= lag) emit_sketch();
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Send one input beat; valid stays high into the next call unless it idles.
  task automatic send_pixel(pix_in_t px);
    bit accepted;
    if (!steady_in && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do begin
      @(negedge clk_i);
      accepted = in_ready_o;
      @(posedge clk_i);
    end while (!accepted);
    take_pixel(px);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic pix_in_t make_pixel(int style);
    pix_in_t px;
    px.flush = 1'b0;
    case (style)
      1: begin
        px.red = 8'($urandom_range(3)); px.green = 8'd0; px.blue = 8'($urandom_range(3));
      end
      2: begin
        // dark field with scattered bright spots, drives the dodge into saturation
        px.red   = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 200)) : 8'd0;
        px.green = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 200)) : 8'd0;
        px.blue  = 8'($urandom_range(255));
      end
      3: begin
        px.red = 8'($urandom_range(255, 180)); px.green = 8'($urandom_range(255, 180));
        px.blue = 8'($urandom_range(255, 180));
      end
      default: begin
        px.red = 8'($urandom); px.green = 8'($urandom); px.blue = 8'($urandom);
      end
    endcase
    return px;
  endfunction

  function automatic pix_in_t flush_beat();
    pix_in_t px;
    px = pix_in_t'($urandom);
    px.flush = 1'b1;
    return px;
  endfunction

  // Hold until every expected result is out and the block has gone quiet.
  task automatic wait_idle();
    drop_valid();
    while (sketch_q.size() != 0) @(posedge clk_i);
    repeat (HoldOff) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, int unsigned value);
    bit accepted;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgDataW'(value);
    do begin
      @(negedge clk_i);
      accepted = cfg_ready_o;
      @(posedge clk_i);
    end while (!accepted);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) width_reg = value & 12'hFFF;
    else if (idx == CFG_FRAME_HEIGHT) height_reg = value & 13'h1FFF;
    else return;
    restart_frame();
  endtask

  task automatic set_frame(int unsigned w, int unsigned h);
    wait_idle();
    cfg_write(CFG_FRAME_WIDTH, w);
    cfg_write(CFG_FRAME_HEIGHT, h);
  endtask

  // Feed a whole frame, then drain; pixels during the drain act as flushes.
  task automatic run_frame(int style, int drain_pixels_pct);
    int unsigned total;
    total = eff_width() * eff_height();
    for (int unsigned k = 0; k < total; k++) begin
      send_pixel(make_pixel(style));
      random_items++;
    end
    while (frame_taken) begin
      send_pixel(($urandom_range(99) < drain_pixels_pct) ? make_pixel(0) : flush_beat());
      random_items++;
    end
  endtask

  // Output side: random back-pressure and the result checker.
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else out_ready_i <= steady_out || ($urandom_range(99) >= 38);
  end

  always @(negedge clk_i) begin
    pix_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sketch_q.size() == 0) begin
        report($sformatf("unexpected result %0d/%0b",
                         out_data_o.sketch_value, out_data_o.frame_end));
      end else begin
        want = sketch_q.pop_front();
        if (out_data_o.sketch_value !== want.sketch_value)
          report($sformatf("sketch_value %0d, want %0d",
                           out_data_o.sketch_value, want.sketch_value));
        if (out_data_o.frame_end !== want.frame_end)
          report($sformatf("frame_end %0b, want %0b", out_data_o.frame_end, want.frame_end));
      end
    end
  end

  // Watchdog: count cycles in which no channel moves a beat.
  always @(negedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Default 640x480 frame: a few pixels give no result, colors at their extremes.
  task automatic test_reset_size();
    pix_in_t px;
    px = '0;
    send_pixel(px);
    px.red = 8'hFF; send_pixel(px);
    px = '0; px.green = 8'hFF; send_pixel(px);
    px = '0; px.blue = 8'hFF; send_pixel(px);
    px = '{8'hFF, 8'hFF, 8'hFF, 1'b0}; send_pixel(px);
  endtask

  // Tiny frame with a flush on an idle block, a pixel while draining, and the clamped size.
  task automatic test_directed();
    set_frame(3, 3);
    send_pixel(flush_beat());                 // nothing pending: ignored
    for (int k = 0; k < 9; k++) send_pixel(make_pixel(k % 4));
    send_pixel(make_pixel(0));                // pixel during drain acts as flush
    while (frame_taken) send_pixel(flush_beat());
    send_pixel(flush_beat());
    set_frame(0, 0);                          // clamps to a single pixel
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 1'b0});
    send_pixel(flush_beat());
    wait_idle();
    cfg_write(CfgIdxUnused, 13'h1555);        // unknown register: no effect
    send_pixel('{8'h80, 8'h40, 8'h20, 1'b0});
    send_pixel(flush_beat());
  endtask

  // Largest sizes and register values above the legal range, partial frames only.
  task automatic test_size_extremes();
    set_frame(2048, 1);
    repeat (60) send_pixel(make_pixel(0));    // widest row
    set_frame(1, 4096);
    repeat (200) send_pixel(make_pixel(0));   // tallest frame, wraps the kept rows
    set_frame(2, 8191);                       // clamped height
    repeat (30) send_pixel(make_pixel(0));
    set_frame(4095, 2);                       // clamped width
    repeat (40) send_pixel(make_pixel(0));
  endtask

  // Random small frames with random content; one stretch runs without idling.
  task automatic test_random_frames();
    int unsigned w, h, nframe;
    nframe = 0;
    random_items = 0;
    while (random_items < RandomItems) begin
      if ($urandom_range(4) == 0) begin
        w = $urandom_range(40, 15); h = $urandom_range(20, 15);
      end else begin
        w = $urandom_range(24, 1); h = $urandom_range(18, 1);
      end
      steady_in  = (nframe >= 1 && nframe < 3);
      steady_out = steady_in;
      set_frame(w, h);
      run_frame($urandom_range(3), 15);
      if (nframe == 0) begin
        // hold off new frames until every expected result is out
        drop_valid();
        while (sketch_q.size() != 0) @(posedge clk_i);
      end
      nframe++;
    end
    steady_in  = 1'b0;
    steady_out = 1'b0;
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_FRAME_WIDTH;
    cfg_data_i   = '0;
    mismatches   = 0;
    steady_in    = 1'b0;
    steady_out   = 1'b0;
    width_reg    = 640;
    height_reg   = 480;
    restart_frame();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_size();
    test_directed();
    test_random_frames();
    test_size_extremes();

    wait_idle();
    if (sketch_q.size() != 0) report("results still expected at end");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
